[sv/fcls_pkg.sv]
// shared types and constants of the four-field range rule classifier
package fcls_pkg;

  localparam int MAX_RULES   = 256;
  localparam int FIELD_COUNT = 4;
  localparam int VAL_W       = 32;
  localparam int IDX_W       = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W       = $clog2(MAX_RULES + 1);
  localparam int POS_IN_W    = 8;
  localparam int COUNT_OUT_W = 9;
  localparam int PC_W        = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;
  localparam int CO_W        = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t [FIELD_COUNT-1:0] lo;
    val_t [FIELD_COUNT-1:0] hi;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef enum logic [1:0] {
    ACT_CLASSIFY = 2'd0,
    ACT_INSERT   = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

[sv/fcls_rule_ram.sv]
// simple dual-port rule memory with registered read data
module fcls_rule_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/fcls_match.sv]
// range check of a key against one rule over all four fields
module fcls_match (
  input  fcls_pkg::val_t [fcls_pkg::FIELD_COUNT-1:0] key,
  input  fcls_pkg::rule_t                            rule,
  output logic                                       hit
);

  always_comb begin
    hit = 1'b1;
    for (int f = 0; f < fcls_pkg::FIELD_COUNT; f++) begin
      if ((key[f] < rule.lo[f]) || (key[f] > rule.hi[f])) begin
        hit = 1'b0;
      end
    end
  end

endmodule

[sv/four_field_range_rule_classifier.sv]
// top level: rule table sequencer for classify, insert, remove and clear
// classify reads rules from index 0 up until the first hit or the last rule; insert shifts the
// rules from the end down to the position up by one, then writes the new one; remove shifts the
// rules above it down; clear, rejected requests and classify on an empty table report directly
// throughput: one request at a time, the next is taken once the result is in the output register
// reset: synchronous active-low rst_n empties the table; rule memory contents are not cleared
module four_field_range_rule_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_position,
  input  logic [31:0] in_value1,
  input  logic [31:0] in_value2,
  input  logic [31:0] in_value3,
  input  logic [31:0] in_value4,
  input  logic [31:0] in_upper1,
  input  logic [31:0] in_upper2,
  input  logic [31:0] in_upper3,
  input  logic [31:0] in_upper4,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_match_found,
  output logic [7:0]  out_rule_index,
  output logic [8:0]  out_rule_count
);

  localparam int IDX_W = fcls_pkg::IDX_W;
  localparam int CNT_W = fcls_pkg::CNT_W;
  localparam int PC_W  = fcls_pkg::PC_W;
  localparam int CO_W  = fcls_pkg::CO_W;

  fcls_pkg::state_t  state_r, state_nxt;
  fcls_pkg::rule_t   rule_r, rule_nxt;
  fcls_pkg::rule_t   rd_rule;
  fcls_pkg::status_t status_r, status_nxt;
  fcls_pkg::rule_t   wdata;

  logic [PC_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             issue_r, issue_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0] rd_a_r, rd_a_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;
  logic [1:0]       out_status_r;
  logic             out_found_r;
  logic [7:0]       out_index_r;
  logic [8:0]       out_count_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             rule_hit;
  logic             accept;
  logic [PC_W-1:0]  in_pos_w;
  logic [PC_W-1:0]  cnt_w;
  logic [IDX_W-1:0] cnt_last;
  logic [IDX_W-1:0] pos_idx;
  logic [PC_W-1:0]  hit_ext;
  logic [CO_W-1:0]  cnt_ext;

  fcls_rule_ram #(
    .DEPTH (fcls_pkg::MAX_RULES),
    .WIDTH (fcls_pkg::RULE_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (rd_rule)
  );

  fcls_match u_match (
    .key  (rule_r.lo),
    .rule (rd_rule),
    .hit  (rule_hit)
  );

  assign in_stall = (state_r != fcls_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_pos_w = PC_W'(in_position);
  assign cnt_w    = PC_W'(cnt_r);
  assign cnt_last = IDX_W'(cnt_r - CNT_W'(1));
  assign pos_idx  = pos_r[IDX_W-1:0];
  assign hit_ext  = PC_W'(hit_r);
  assign cnt_ext  = CO_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcls_pkg::S_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rule_r   <= rule_nxt;
    pos_r    <= pos_nxt;
    addr_r   <= addr_nxt;
    rd_a_r   <= rd_a_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    hit_r    <= hit_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_index_r  <= hit_ext[7:0];
      out_count_r  <= cnt_ext[8:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rule_nxt      = rule_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    rd_v_nxt      = 1'b0;
    rd_a_nxt      = addr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    we            = 1'b0;
    waddr         = rd_a_r;
    wdata         = rd_rule;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      fcls_pkg::S_IDLE: begin
        if (in_valid) begin
          rule_nxt.lo = {in_value4, in_value3, in_value2, in_value1};
          rule_nxt.hi = {in_upper4, in_upper3, in_upper2, in_upper1};
          pos_nxt     = in_pos_w;
          status_nxt  = fcls_pkg::STAT_OK;
          found_nxt   = 1'b0;
          hit_nxt     = '0;
          addr_nxt    = '0;
          issue_nxt   = 1'b0;
          state_nxt   = fcls_pkg::S_DONE;
          unique case (fcls_pkg::action_t'(in_action))
            fcls_pkg::ACT_CLASSIFY: begin
              if (cnt_r != '0) begin
                issue_nxt = 1'b1;
                state_nxt = fcls_pkg::S_CLASSIFY;
              end
            end
            fcls_pkg::ACT_INSERT: begin
              if (in_pos_w > cnt_w) begin
                status_nxt = fcls_pkg::STAT_RANGE;
              end else if (cnt_r == CNT_W'(fcls_pkg::MAX_RULES)) begin
                status_nxt = fcls_pkg::STAT_FULL;
              end else if (in_pos_w == cnt_w) begin
                state_nxt = fcls_pkg::S_WRITE;
              end else begin
                addr_nxt  = cnt_last;
                issue_nxt = 1'b1;
                state_nxt = fcls_pkg::S_SHIFT_UP;
              end
            end
            fcls_pkg::ACT_REMOVE: begin
              if (in_pos_w >= cnt_w) begin
                status_nxt = fcls_pkg::STAT_RANGE;
              end else if (in_pos_w == (cnt_w - PC_W'(1))) begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end else begin
                addr_nxt  = in_pos_w[IDX_W-1:0] + IDX_W'(1);
                issue_nxt = 1'b1;
                state_nxt = fcls_pkg::S_SHIFT_DOWN;
              end
            end
            fcls_pkg::ACT_CLEAR: begin
              cnt_nxt = '0;
            end
          endcase
        end
      end

      fcls_pkg::S_CLASSIFY: begin
        rd_v_nxt = issue_r;
        if (issue_r) begin
          if (addr_r == cnt_last) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + IDX_W'(1);
          end
        end
        if (rd_v_r && rule_hit) begin
          found_nxt = 1'b1;
          hit_nxt   = rd_a_r;
          issue_nxt = 1'b0;
          state_nxt = fcls_pkg::S_DONE;
        end else if (rd_v_r && (rd_a_r == cnt_last)) begin
          state_nxt = fcls_pkg::S_DONE;
        end
      end

      fcls_pkg::S_SHIFT_UP: begin
        rd_v_nxt = issue_r;
        if (issue_r) begin
          if (addr_r == pos_idx) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r - IDX_W'(1);
          end
        end
        if (rd_v_r) begin
          we    = 1'b1;
          waddr = rd_a_r + IDX_W'(1);
          if (rd_a_r == pos_idx) begin
            state_nxt = fcls_pkg::S_WRITE;
          end
        end
      end

      fcls_pkg::S_SHIFT_DOWN: begin
        rd_v_nxt = issue_r;
        if (issue_r) begin
          if (addr_r == cnt_last) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + IDX_W'(1);
          end
        end
        if (rd_v_r) begin
          we    = 1'b1;
          waddr = rd_a_r - IDX_W'(1);
          if (rd_a_r == cnt_last) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = fcls_pkg::S_DONE;
          end
        end
      end

      fcls_pkg::S_WRITE: begin
        we        = 1'b1;
        waddr     = pos_idx;
        wdata     = rule_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = fcls_pkg::S_DONE;
      end

      fcls_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fcls_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fcls_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_found = out_found_r;
  assign out_rule_index  = out_index_r;
  assign out_rule_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(fcls_pkg::MAX_RULES))
    else $error("rule count above table size");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcls_pkg::S_IDLE && !accept) |=> $stable(cnt_r))
    else $error("rule count changed without a request");

  a_shift_up_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcls_pkg::S_SHIFT_UP && we) |-> (waddr > pos_idx))
    else $error("shift up wrote at or below the insert position");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_found) |-> (out_status == fcls_pkg::STAT_OK))
    else $error("match reported with an error status");

endmodule

[tb/sv/four_field_range_rule_classifier_tb.sv]
// self-checking testbench of the four-field range rule classifier with a rule table scoreboard
module four_field_range_rule_classifier_tb;

  localparam fcls_pkg::val_t TOP = 32'hFFFF_FFFF;
  localparam int PEND_DEPTH = 2048;

  typedef struct packed {
    fcls_pkg::action_t                          action;
    logic [7:0]                                 position;
    fcls_pkg::val_t [fcls_pkg::FIELD_COUNT-1:0] lo;
    fcls_pkg::val_t [fcls_pkg::FIELD_COUNT-1:0] hi;
  } request_t;

  typedef struct packed {
    fcls_pkg::status_t status;
    logic              match;
    logic [7:0]        index;
    logic [8:0]        count;
  } verdict_t;

  class rule_scoreboard;
    fcls_pkg::val_t lo_tab [fcls_pkg::MAX_RULES][fcls_pkg::FIELD_COUNT];
    fcls_pkg::val_t hi_tab [fcls_pkg::MAX_RULES][fcls_pkg::FIELD_COUNT];
    int             rule_total;
    int             mismatches;
    verdict_t       pending [PEND_DEPTH];
    int             n_noted;
    int             n_checked;

    function new();
      rule_total = 0;
      mismatches = 0;
      n_noted    = 0;
      n_checked  = 0;
    endfunction

    function int outstanding();
      return n_noted - n_checked;
    endfunction

    function void note_request(request_t req);
      verdict_t want;
      int       r;
      int       f;
      int       pos;
      bit       hit;
      want.status = fcls_pkg::STAT_OK;
      want.match  = 1'b0;
      want.index  = 8'd0;
      pos = req.position;
      case (req.action)
        fcls_pkg::ACT_CLASSIFY: begin
          for (r = 0; r < rule_total && !want.match; r++) begin
            hit = 1'b1;
            for (f = 0; f < fcls_pkg::FIELD_COUNT; f++)
              if (req.lo[f] < lo_tab[r][f] || req.lo[f] > hi_tab[r][f]) hit = 1'b0;
            if (hit) begin
              want.match = 1'b1;
              want.index = r[7:0];
            end
          end
        end
        fcls_pkg::ACT_INSERT: begin
          if (pos > rule_total) want.status = fcls_pkg::STAT_RANGE;
          else if (rule_total >= fcls_pkg::MAX_RULES) want.status = fcls_pkg::STAT_FULL;
          else begin
            for (r = rule_total; r > pos; r--) begin
              lo_tab[r] = lo_tab[r-1];
              hi_tab[r] = hi_tab[r-1];
            end
            for (f = 0; f < fcls_pkg::FIELD_COUNT; f++) begin
              lo_tab[pos][f] = req.lo[f];
              hi_tab[pos][f] = req.hi[f];
            end
            rule_total++;
          end
        end
        fcls_pkg::ACT_REMOVE: begin
          if (pos >= rule_total) want.status = fcls_pkg::STAT_RANGE;
          else begin
            for (r = pos; r < rule_total - 1; r++) begin
              lo_tab[r] = lo_tab[r+1];
              hi_tab[r] = hi_tab[r+1];
            end
            rule_total--;
          end
        end
        default: rule_total = 0;
      endcase
      want.count = rule_total[8:0];
      pending[n_noted % PEND_DEPTH] = want;
      n_noted++;
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (outstanding() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status %0d match %0d index %0d count %0d",
                   $time, got.status, got.match, got.index, got.count);
        return;
      end
      want = pending[n_checked % PEND_DEPTH];
      n_checked++;
      if (got.status !== want.status || got.match !== want.match ||
          got.index !== want.index || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch expected status %0d match %0d index %0d count %0d,",
                    " got %0d %0d %0d %0d"},
                   $time, want.status, want.match, want.index, want.count,
                   got.status, got.match, got.index, got.count);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_position;
  logic [31:0] in_value1;
  logic [31:0] in_value2;
  logic [31:0] in_value3;
  logic [31:0] in_value4;
  logic [31:0] in_upper1;
  logic [31:0] in_upper2;
  logic [31:0] in_upper3;
  logic [31:0] in_upper4;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_match_found;
  logic [7:0]  out_rule_index;
  logic [8:0]  out_rule_count;

  rule_scoreboard sb = new();
  bit             quiet;
  int             sent;

  four_field_range_rule_classifier dut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #4000000;
    $display("four_field_range_rule_classifier_tb: errors");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(verdict_t'{fcls_pkg::status_t'(out_status), out_match_found,
                                 out_rule_index, out_rule_count});

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 14)) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  function automatic request_t uniform(fcls_pkg::action_t a, logic [7:0] p,
                                       fcls_pkg::val_t l, fcls_pkg::val_t h);
    request_t q;
    int       f;
    q.action   = a;
    q.position = p;
    for (f = 0; f < fcls_pkg::FIELD_COUNT; f++) begin
      q.lo[f] = l;
      q.hi[f] = h;
    end
    return q;
  endfunction

  function automatic logic [7:0] stray_position(int from);
    if (from <= 255) return 8'($urandom_range(from, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // key value inside a rule range, edges favored
  function automatic fcls_pkg::val_t pick_in(fcls_pkg::val_t a, fcls_pkg::val_t b);
    if (a > b) return $urandom;
    case ($urandom_range(0, 9))
      0: return a;
      1: return b;
      default: begin
        if (a == 0 && b == TOP) return $urandom;
        return $urandom_range(b, a);
      end
    endcase
  endfunction

  function automatic request_t make_insert(bit in_range);
    request_t       q;
    int             f;
    fcls_pkg::val_t span;
    q.action = fcls_pkg::ACT_INSERT;
    if (!in_range) q.position = stray_position(sb.rule_total + 1);
    else if (sb.rule_total > 255) q.position = 8'd255;
    else q.position = 8'($urandom_range(0, sb.rule_total));
    for (f = 0; f < fcls_pkg::FIELD_COUNT; f++) begin
      case ($urandom_range(0, 19))
        0, 1: begin q.lo[f] = 0; q.hi[f] = TOP; end
        2, 3: begin q.lo[f] = $urandom; q.hi[f] = q.lo[f]; end
        4, 5: begin q.lo[f] = $urandom; q.hi[f] = $urandom; end
        6: begin q.lo[f] = 0; q.hi[f] = $urandom_range(0, 1000); end
        7: begin q.hi[f] = TOP; q.lo[f] = TOP - $urandom_range(0, 1000); end
        default: begin
          q.lo[f] = $urandom;
          span    = $urandom_range(0, 4095);
          q.hi[f] = (q.lo[f] > TOP - span) ? TOP : q.lo[f] + span;
        end
      endcase
    end
    return q;
  endfunction

  function automatic request_t make_classify();
    request_t q;
    int       f;
    int       r;
    q.action   = fcls_pkg::ACT_CLASSIFY;
    q.position = 8'($urandom_range(0, 255));
    for (f = 0; f < fcls_pkg::FIELD_COUNT; f++) q.hi[f] = $urandom;
    if (sb.rule_total > 0 && $urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, sb.rule_total - 1);
      for (f = 0; f < fcls_pkg::FIELD_COUNT; f++)
        q.lo[f] = pick_in(sb.lo_tab[r][f], sb.hi_tab[r][f]);
    end else begin
      for (f = 0; f < fcls_pkg::FIELD_COUNT; f++)
        case ($urandom_range(0, 3))
          0: q.lo[f] = 0;
          1: q.lo[f] = TOP;
          default: q.lo[f] = $urandom;
        endcase
    end
    return q;
  endfunction

  function automatic request_t make_remove(bit in_range);
    request_t q;
    q = uniform(fcls_pkg::ACT_REMOVE, 8'd0, $urandom, $urandom);
    q.lo[1] = $urandom;
    q.hi[3] = $urandom;
    if (in_range && sb.rule_total > 0)
      q.position = 8'($urandom_range(0, sb.rule_total - 1));
    else q.position = stray_position(sb.rule_total);
    return q;
  endfunction

  function automatic request_t make_mixed();
    int pick;
    int ins_w;
    pick  = $urandom_range(0, 99);
    ins_w = (sb.rule_total > 200) ? 18 : 28;
    if (pick < 2)
      return uniform(fcls_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), $urandom, $urandom);
    if (pick < 52) return make_classify();
    if (pick < 52 + ins_w) return make_insert($urandom_range(0, 7) != 0);
    return make_remove($urandom_range(0, 7) != 0);
  endfunction

  task automatic send_request(request_t q);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_action   <= q.action;
    in_position <= q.position;
    in_value1   <= q.lo[0];
    in_value2   <= q.lo[1];
    in_value3   <= q.lo[2];
    in_value4   <= q.lo[3];
    in_upper1   <= q.hi[0];
    in_upper2   <= q.hi[1];
    in_upper3   <= q.hi[2];
    in_upper4   <= q.hi[3];
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(q);
    sent++;
  endtask

  initial begin
    request_t q;
    int       guard;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = fcls_pkg::ACT_CLASSIFY;
    in_position = '0;
    in_value1   = '0;
    in_value2   = '0;
    in_value3   = '0;
    in_value4   = '0;
    in_upper1   = '0;
    in_upper2   = '0;
    in_upper3   = '0;
    in_upper4   = '0;
    quiet       = 1'b0;
    sent        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table and out-of-range positions
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, TOP, TOP));
    send_request(uniform(fcls_pkg::ACT_REMOVE, 8'd0, 0, 0));
    send_request(uniform(fcls_pkg::ACT_INSERT, 8'd1, 0, TOP));
    send_request(uniform(fcls_pkg::ACT_INSERT, 8'd255, 0, TOP));
    // wildcard, point at top, narrow, inverted
    send_request(uniform(fcls_pkg::ACT_INSERT, 8'd0, 0, TOP));
    send_request(uniform(fcls_pkg::ACT_INSERT, 8'd0, TOP, TOP));
    send_request(uniform(fcls_pkg::ACT_INSERT, 8'd1, 32'h8000_0000, 32'h8000_00FF));
    q = uniform(fcls_pkg::ACT_INSERT, 8'd0, 0, TOP);
    q.lo[2] = 32'd10;
    q.hi[2] = 32'd5;
    send_request(q);
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, TOP, TOP));
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, 0, 0));
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, 32'h8000_0080, 0));
    q = uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, 32'h8000_00FF, 0);
    q.lo[3] = 32'h8000_0100;
    send_request(q);
    q = uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, 0, 0);
    q.lo[2] = 32'd7;
    send_request(q);
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555));
    send_request(uniform(fcls_pkg::ACT_REMOVE, 8'd4, 0, 0));
    send_request(uniform(fcls_pkg::ACT_REMOVE, 8'd3, 0, 0));
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, 0, 0));
    send_request(uniform(fcls_pkg::ACT_REMOVE, 8'd0, 0, 0));
    send_request(uniform(fcls_pkg::ACT_INSERT, 8'd2, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(uniform(fcls_pkg::ACT_CLEAR, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, 0, 0));
    send_request(uniform(fcls_pkg::ACT_REMOVE, 8'd0, 0, 0));
    send_request(uniform(fcls_pkg::ACT_INSERT, 8'd0, 0, TOP));
    send_request(uniform(fcls_pkg::ACT_CLASSIFY, 8'd0, 32'h1234_5678, 0));

    while (sent < 380) send_request(make_mixed());

    // fill the table, then work at the full boundary
    while (sb.rule_total < fcls_pkg::MAX_RULES)
      send_request(($urandom_range(0, 5) == 0) ? make_classify() : make_insert(1'b1));
    send_request(make_insert(1'b1));
    q = make_remove(1'b1);
    q.position = 8'd255;
    send_request(q);
    q = make_insert(1'b1);
    q.position = 8'd255;
    send_request(q);
    send_request(make_insert(1'b1));
    repeat (40) send_request(make_mixed());

    while (sent < 1050) begin
      if (sent >= 900) quiet = 1'b1;
      send_request(make_mixed());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    guard = 0;
    while (sb.outstanding() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("four_field_range_rule_classifier_tb: clean");
    else
      $display("four_field_range_rule_classifier_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
sv/fcls_pkg.sv
sv/fcls_rule_ram.sv
sv/fcls_match.sv
sv/four_field_range_rule_classifier.sv
tb/sv/four_field_range_rule_classifier_tb.sv
